>>> src/ppt_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the projective point transform.
// No dependencies.
package ppt_pkg;
   localparam int unsigned WordW = 32;
   localparam int unsigned CoefW = 64;
   localparam int unsigned SumW  = 65;   // signed row sum, magnitude below 2^64
   localparam int unsigned CsrIdxW = 3;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_M00_M01 = 3'd0,
      CSR_M02_M10 = 3'd1,
      CSR_M11_M12 = 3'd2,
      CSR_M20_M21 = 3'd3,
      CSR_M22     = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic valid;
      logic inf;
      logic nneg_x;
      logic nneg_y;
      logic dneg;
   } ctl_type;
endpackage

>>> src/projective_point_transform.sv
`timescale 1ns / 1ps
// Top level: 3x3 homography on Q fixed-point homogeneous points.
// Depends on ppt_pkg and ppt_div.
//
//  channel | direction | tdata bits (low first)        | tuser
//  req     | in        | in_w[31:0] in_x[31:0] in_y    | -
//  rsp     | out       | out_x[31:0] out_y[31:0]       | at_infinity, saturated
//  csr     | in        | 64-bit write, index 0..4      | -
//
// One request per cycle unless the output stalls; the divider resolves one bit
// per stage. The whole pipe advances when the output register is empty or
// being taken. Reset is synchronous and restores the identity.
module projective_point_transform #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // in_w, in_x, in_y
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // out_x, out_y
   output logic [1:0]   rsp_tuser,   // at_infinity, saturated
   input  logic         csr_we,
   input  logic [2:0]   csr_idx,
   input  logic [63:0]  csr_wdata
);
   localparam logic [31:0] One = 32'(1) << FRAC_BITS;

   logic [63:0] c0_ff, c1_ff, c2_ff, c3_ff;
   logic [31:0] c4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_ff <= {32'd0, One};
         c1_ff <= '0;
         c2_ff <= {32'd0, One};
         c3_ff <= '0;
         c4_ff <= One;
      end else if (csr_we) begin
         case (ppt_pkg::csr_idx_type'(csr_idx))
            ppt_pkg::CSR_M00_M01: c0_ff <= csr_wdata;
            ppt_pkg::CSR_M02_M10: c1_ff <= csr_wdata;
            ppt_pkg::CSR_M11_M12: c2_ff <= csr_wdata;
            ppt_pkg::CSR_M20_M21: c3_ff <= csr_wdata;
            ppt_pkg::CSR_M22:     c4_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic rsp_vld_ff;
   assign adv        = ~rsp_vld_ff | rsp_tready;
   assign req_tready = adv;

   // stage 1: nine products
   logic signed [31:0] m [9];
   always_comb begin
      m[0] = c0_ff[31:0];  m[1] = c0_ff[63:32]; m[2] = c1_ff[31:0];
      m[3] = c1_ff[63:32]; m[4] = c2_ff[31:0];  m[5] = c2_ff[63:32];
      m[6] = c3_ff[31:0];  m[7] = c3_ff[63:32]; m[8] = c4_ff;
   end
   logic signed [31:0] v [3];
   assign v[0] = req_tdata[31:0];
   assign v[1] = req_tdata[63:32];
   assign v[2] = req_tdata[95:64];

   logic signed [63:0] prod_ff [9];
   logic [2:0]         vld_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 9; i++) begin
            prod_ff[i] <= m[i] * v[i%3];
         end
      end
   end

   // stage 2: row sums
   logic signed [65:0] sum_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            sum_ff[r] <= 66'(prod_ff[3*r]) + 66'(prod_ff[3*r+1]) + 66'(prod_ff[3*r+2]);
         end
      end
   end

   // stage 3: sign / magnitude
   logic [63:0] mag_ff [3];
   logic        neg_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            neg_ff[r] <= sum_ff[r][65];
            mag_ff[r] <= sum_ff[r][65] ? 64'(-sum_ff[r]) : sum_ff[r][63:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[1:0], req_tvalid};
      end
   end

   ppt_pkg::ctl_type dctl, octl;
   always_comb begin
      dctl.valid  = vld_ff[2];
      dctl.inf    = mag_ff[0] == '0;
      dctl.nneg_x = neg_ff[1];
      dctl.nneg_y = neg_ff[2];
      dctl.dneg   = neg_ff[0];
   end

   logic        dv, bx, by;
   logic [32:0] qx, qy;
   ppt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(vld_ff[2]), .in_nx(mag_ff[1]), .in_ny(mag_ff[2]),
      .in_den(dctl.inf ? 64'd1 : mag_ff[0]), .in_ctl(dctl),
      .out_valid(dv), .out_qx(qx), .out_bigx(bx), .out_qy(qy), .out_bigy(by),
      .out_ctl(octl)
   );

   logic [31:0] ox_in, oy_in;
   logic        sx_in, sy_in;
   always_comb begin
      if (octl.nneg_x != octl.dneg) begin
         sx_in = bx | (qx > 33'h080000000);
         ox_in = sx_in ? 32'h80000000 : 32'(-qx);
      end else begin
         sx_in = bx | (qx > 33'h07FFFFFFF);
         ox_in = sx_in ? 32'h7FFFFFFF : qx[31:0];
      end
      if (octl.nneg_y != octl.dneg) begin
         sy_in = by | (qy > 33'h080000000);
         oy_in = sy_in ? 32'h80000000 : 32'(-qy);
      end else begin
         sy_in = by | (qy > 33'h07FFFFFFF);
         oy_in = sy_in ? 32'h7FFFFFFF : qy[31:0];
      end
   end

   logic [63:0] rdata_ff;
   logic [1:0]  ruser_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= dv;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rdata_ff <= octl.inf ? 64'd0 : {oy_in, ox_in};
         ruser_ff <= octl.inf ? 2'b01 : {sx_in | sy_in, 1'b0};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = ruser_ff;
endmodule

>>> src/ppt_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, two quotients.
// Depends on ppt_pkg.
module ppt_div #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [63:0]                 in_nx,
   input  logic [63:0]                 in_ny,
   input  logic [63:0]                 in_den,
   input  ppt_pkg::ctl_type            in_ctl,
   output logic                        out_valid,
   output logic [32:0]                 out_qx,
   output logic                        out_bigx,
   output logic [32:0]                 out_qy,
   output logic                        out_bigy,
   output ppt_pkg::ctl_type            out_ctl
);
   localparam int unsigned Steps = 64 + FRAC_BITS;

   logic [Steps:0]      vld_ff;
   logic [64:0]         remx_ff [Steps+1];
   logic [64:0]         remy_ff [Steps+1];
   logic [63:0]         numx_ff [Steps+1];
   logic [63:0]         numy_ff [Steps+1];
   logic [32:0]         qx_ff   [Steps+1];
   logic [32:0]         qy_ff   [Steps+1];
   logic                bx_ff   [Steps+1];
   logic                by_ff   [Steps+1];
   logic [63:0]         den_ff  [Steps+1];
   ppt_pkg::ctl_type    ctl_ff  [Steps+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Steps-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         remx_ff[0] <= '0;
         remy_ff[0] <= '0;
         numx_ff[0] <= in_nx;
         numy_ff[0] <= in_ny;
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
         bx_ff[0]   <= 1'b0;
         by_ff[0]   <= 1'b0;
         den_ff[0]  <= in_den;
         ctl_ff[0]  <= in_ctl;
      end
   end

   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic [64:0] shx_in, shy_in, rx_in, ry_in;
      logic        gx_in, gy_in;
      always_comb begin
         shx_in = {remx_ff[s][63:0], numx_ff[s][63]};
         shy_in = {remy_ff[s][63:0], numy_ff[s][63]};
         gx_in  = shx_in >= {1'b0, den_ff[s]};
         gy_in  = shy_in >= {1'b0, den_ff[s]};
         rx_in  = gx_in ? shx_in - {1'b0, den_ff[s]} : shx_in;
         ry_in  = gy_in ? shy_in - {1'b0, den_ff[s]} : shy_in;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            remx_ff[s+1] <= rx_in;
            remy_ff[s+1] <= ry_in;
            numx_ff[s+1] <= {numx_ff[s][62:0], 1'b0};
            numy_ff[s+1] <= {numy_ff[s][62:0], 1'b0};
            den_ff[s+1]  <= den_ff[s];
            ctl_ff[s+1]  <= ctl_ff[s];
            bx_ff[s+1]   <= bx_ff[s] | (~bx_ff[s] & qx_ff[s][32]);
            by_ff[s+1]   <= by_ff[s] | (~by_ff[s] & qy_ff[s][32]);
            qx_ff[s+1]   <= (bx_ff[s] | qx_ff[s][32]) ? qx_ff[s]
                            : {qx_ff[s][31:0], gx_in};
            qy_ff[s+1]   <= (by_ff[s] | qy_ff[s][32]) ? qy_ff[s]
                            : {qy_ff[s][31:0], gy_in};
         end
      end
   end

   assign out_valid = vld_ff[Steps];
   assign out_qx    = qx_ff[Steps];
   assign out_bigx  = bx_ff[Steps] | qx_ff[Steps][32];
   assign out_qy    = qy_ff[Steps];
   assign out_bigy  = by_ff[Steps] | qy_ff[Steps][32];
   assign out_ctl   = ctl_ff[Steps];
endmodule
